### rtl/core/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types, constants and control program for the pulse rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

   localparam int NUM_BUCKETS_DEF = 4;
   localparam int TIME_W          = 32;
   localparam int COUNT_W         = 16;
   localparam int RATE_W          = 32;
   localparam int REFR_W          = 16;
   localparam int DIV_CNT_W       = $clog2(RATE_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_COUNT_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_REFRACTORY   = CSR_IDX_W'(1);

   localparam logic [REFR_W-1:0] REFRACTORY_RESET = REFR_W'(500);
   localparam logic [RATE_W-1:0] RATE_SCALE       = RATE_W'(60000);

   localparam logic ACTION_PULSE = 1'b0;
   localparam logic ACTION_RATE  = 1'b1;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_DISPATCH = 4'd1;
   localparam step_type STEP_PULSE    = 4'd2;
   localparam step_type STEP_ADVANCE  = 4'd3;
   localparam step_type STEP_SUM      = 4'd4;
   localparam step_type STEP_RESTAMP  = 4'd5;
   localparam step_type STEP_SCALE    = 4'd6;
   localparam step_type STEP_DIVIDE   = 4'd7;
   localparam step_type STEP_OUTPUT   = 4'd8;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_PULSE,
      OP_ADVANCE,
      OP_SUM,
      OP_RESTAMP,
      OP_SCALE,
      OP_DIVIDE,
      OP_OUTPUT
   } op_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_RATE,
      C_SCAN_LAST,
      C_DELTA_ZERO,
      C_DIV_LAST,
      C_OUT_FREE
   } cond_type;

   // cond true: go to target; false: stay if hold, else next step
   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     hold;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type rom_read(input step_type step);
      ctrl_word_type cw;
      unique case (step)
         STEP_IDLE:     cw = '{OP_ACCEPT,  C_ACCEPT,     1'b1, STEP_DISPATCH};
         STEP_DISPATCH: cw = '{OP_NOP,     C_RATE,       1'b0, STEP_ADVANCE};
         STEP_PULSE:    cw = '{OP_PULSE,   C_ALWAYS,     1'b0, STEP_IDLE};
         STEP_ADVANCE:  cw = '{OP_ADVANCE, C_ALWAYS,     1'b0, STEP_SUM};
         STEP_SUM:      cw = '{OP_SUM,     C_SCAN_LAST,  1'b1, STEP_RESTAMP};
         STEP_RESTAMP:  cw = '{OP_RESTAMP, C_ALWAYS,     1'b0, STEP_SCALE};
         STEP_SCALE:    cw = '{OP_SCALE,   C_DELTA_ZERO, 1'b0, STEP_OUTPUT};
         STEP_DIVIDE:   cw = '{OP_DIVIDE,  C_DIV_LAST,   1'b1, STEP_OUTPUT};
         STEP_OUTPUT:   cw = '{OP_OUTPUT,  C_OUT_FREE,   1'b1, STEP_IDLE};
         default:       cw = '{OP_NOP,     C_ALWAYS,     1'b0, STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pulse_rate_meter_top.sv
// ----------------------------------------------------------------------------
// pulse_rate_meter_top
// Beat counter over a ring of buckets with a beats-per-minute rate request.
// ----------------------------------------------------------------------------
// A pulse request passes through the dispatch and pulse steps before the
// block is ready again. For a rate request the sum reads one bucket at a
// time, then a restoring divider retires one quotient bit per cycle; with
// zero elapsed time the divider is skipped. All work is steered by a small
// control program, one step per cycle. The result sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module pulse_rate_meter_top
   import prm_pkg::*;
#(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [TIME_W-1:0]     req_tdata,   // [31:0] now_ms
   input  wire logic                  req_tuser,   // [0] action

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RATE_W-1:0]     rsp_tdata,   // [31:0] beats_per_minute

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_BUCKETS);
   localparam int ACC_W = COUNT_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

   step_type             pc_ff, pc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 enable_ff, enable_in;
   logic [REFR_W-1:0]    refr_ff, refr_in;
   logic [TIME_W-1:0]    last_beat_ff, last_beat_in;
   logic [COUNT_W-1:0]   counts_ff [NUM_BUCKETS];
   logic [COUNT_W-1:0]   counts_in [NUM_BUCKETS];
   logic [TIME_W-1:0]    times_ff [NUM_BUCKETS];
   logic [TIME_W-1:0]    times_in [NUM_BUCKETS];
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 action_ff, action_in;
   logic [TIME_W-1:0]    delta_ff, delta_in;
   logic [RATE_W-1:0]    quo_ff, quo_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   ctrl_word_type        cw;
   logic                 cond;
   logic [IDX_W-1:0]     rd_idx;
   logic [COUNT_W-1:0]   count_rd;
   logic [TIME_W-1:0]    gap;
   logic [TIME_W:0]      rem_sh;
   logic                 quo_bit;
   logic                 req_fire;
   logic                 rsp_fire;

   assign cw         = rom_read(pc_ff);
   assign req_tready = (pc_ff == STEP_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign rd_idx   = (cw.op == OP_SUM) ? scan_ff : ptr_ff;
   assign count_rd = counts_ff[rd_idx];
   assign gap      = now_ff - last_beat_ff;
   assign rem_sh   = {rem_ff, quo_ff[RATE_W-1]};
   assign quo_bit  = (rem_sh >= {1'b0, delta_ff});

   always_comb begin
      unique case (cw.cond)
         C_ALWAYS:     cond = 1'b1;
         C_ACCEPT:     cond = req_tvalid;
         C_RATE:       cond = (action_ff == ACTION_RATE);
         C_SCAN_LAST:  cond = (scan_ff == LAST_IDX);
         C_DELTA_ZERO: cond = (delta_ff == '0);
         C_DIV_LAST:   cond = (div_cnt_ff == DIV_CNT_W'(RATE_W - 1));
         C_OUT_FREE:   cond = !rsp_valid_ff;
         default:      cond = 1'b1;
      endcase
   end

   always_comb begin
      if (cond) begin
         pc_in = cw.target;
      end else if (cw.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + step_type'(1);
      end
   end

   always_comb begin
      enable_in    = enable_ff;
      refr_in      = refr_ff;
      last_beat_in = last_beat_ff;
      counts_in    = counts_ff;
      times_in     = times_ff;
      ptr_in       = ptr_ff;
      scan_in      = scan_ff;
      acc_in       = acc_ff;
      now_in       = now_ff;
      action_in    = action_ff;
      delta_in     = delta_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_COUNT_ENABLE) begin
            enable_in = csr_wdata[0];
         end else if (csr_index == REG_REFRACTORY) begin
            refr_in = csr_wdata[REFR_W-1:0];
         end
      end

      unique case (cw.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               now_in    = req_tdata;
               action_in = req_tuser;
            end
         end
         OP_PULSE: begin
            if (enable_ff && (gap > TIME_W'(refr_ff))) begin
               counts_in[ptr_ff] = count_rd + COUNT_W'(1);
               last_beat_in      = now_ff;
            end
         end
         OP_ADVANCE: begin
            ptr_in  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
            scan_in = '0;
            acc_in  = '0;
         end
         OP_SUM: begin
            acc_in  = acc_ff + ACC_W'(count_rd);
            scan_in = scan_ff + IDX_W'(1);
         end
         OP_RESTAMP: begin
            delta_in          = last_beat_ff - times_ff[ptr_ff];
            times_in[ptr_ff]  = now_ff;
            counts_in[ptr_ff] = '0;
         end
         OP_SCALE: begin
            quo_in     = RATE_W'(RATE_W'(acc_ff) * RATE_SCALE);
            rem_in     = '0;
            div_cnt_in = '0;
         end
         OP_DIVIDE: begin
            // restoring division, one quotient bit per step
            rem_in     = quo_bit ? TIME_W'(rem_sh - {1'b0, delta_ff}) : rem_sh[TIME_W-1:0];
            quo_in     = {quo_ff[RATE_W-2:0], quo_bit};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         OP_OUTPUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (delta_ff == '0) ? '0 : quo_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         refr_ff      <= REFRACTORY_RESET;
         last_beat_ff <= '0;
         ptr_ff       <= '0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            counts_ff[i] <= '0;
            times_ff[i]  <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
         refr_ff      <= refr_in;
         last_beat_ff <= last_beat_in;
         ptr_ff       <= ptr_in;
         counts_ff    <= counts_in;
         times_ff     <= times_in;
      end
      scan_ff     <= scan_in;
      acc_ff      <= acc_in;
      now_ff      <= now_in;
      action_ff   <= action_in;
      delta_ff    <= delta_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_IDX)
      else $error("bucket pointer outside ring");

   a_zero_delta_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_OUTPUT && !rsp_valid_ff && delta_ff == '0) |=> (rsp_tdata == '0))
      else $error("zero elapsed time gave nonzero rate");

   a_pulse_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == ACTION_PULSE && !rsp_valid_ff) |=> !rsp_tvalid)
      else $error("pulse request raised a result");

endmodule

`default_nettype wire

### verif/pulse_rate_meter_monitor.sv
// ----------------------------------------------------------------------------
// pulse_rate_meter_monitor
// Watches the request, response and CSR channels of the pulse rate meter,
// tracks the beat buckets on its own and checks every beats-per-minute value.
// ----------------------------------------------------------------------------

module pulse_rate_meter_monitor
   import prm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [TIME_W-1:0]     req_tdata,   // [31:0] now_ms
   input  wire logic                  req_tuser,   // [0] action

   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RATE_W-1:0]     rsp_tdata,   // [31:0] beats_per_minute

   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,

   output int                         mismatches,
   output int                         rates_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUCKETS    = NUM_BUCKETS_DEF;
   localparam int SHOW_LIMIT = 10;

   logic               beats_enabled;
   logic [REFR_W-1:0]  refractory;
   logic [TIME_W-1:0]  last_beat;
   logic [COUNT_W-1:0] bucket_beats  [BUCKETS];
   logic [TIME_W-1:0]  bucket_stamps [BUCKETS];
   int unsigned        ring_pos;
   logic [RATE_W-1:0]  expected_bpm [$];
   int                 failures = 0;

   task automatic take_request(input logic act, input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] since_beat;
      logic [TIME_W-1:0] elapsed;
      logic [RATE_W-1:0] total;
      logic [RATE_W-1:0] scaled;
      since_beat = now_ms - last_beat;
      if (act == ACTION_PULSE) begin
         if (beats_enabled && since_beat > TIME_W'(refractory)) begin
            bucket_beats[ring_pos] = bucket_beats[ring_pos] + 1'b1;
            last_beat = now_ms;
         end
      end else begin
         ring_pos = (ring_pos + 1) % BUCKETS;
         total = '0;
         for (int i = 0; i < BUCKETS; i++) begin
            total = total + RATE_W'(bucket_beats[i]);
         end
         elapsed = last_beat - bucket_stamps[ring_pos];
         bucket_stamps[ring_pos] = now_ms;
         bucket_beats[ring_pos]  = '0;
         scaled = total * RATE_SCALE;
         expected_bpm.push_back((elapsed == '0) ? RATE_W'(0) : scaled / elapsed);
      end
   endtask

   always @(posedge clock) begin
      logic [RATE_W-1:0] want;
      if (reset) begin
         beats_enabled = 1'b0;
         refractory    = REFRACTORY_RESET;
         last_beat     = '0;
         ring_pos      = 0;
         for (int i = 0; i < BUCKETS; i++) begin
            bucket_beats[i]  = '0;
            bucket_stamps[i] = '0;
         end
         expected_bpm.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_COUNT_ENABLE) begin
               beats_enabled = csr_wdata[0];
            end else if (csr_index == REG_REFRACTORY) begin
               refractory = csr_wdata[REFR_W-1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bpm.size() == 0) begin
               if (failures < SHOW_LIMIT) begin
                  $display("%0t: rate response %0d with no rate request pending",
                           $time, rsp_tdata);
               end
               failures++;
            end else begin
               want = expected_bpm.pop_front();
               if (rsp_tdata !== want) begin
                  if (failures < SHOW_LIMIT) begin
                     $display("%0t: beats_per_minute expected %0d got %0d",
                              $time, want, rsp_tdata);
                  end
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_request(req_tuser, req_tdata);
         end
      end
      mismatches        <= failures;
      rates_outstanding <= expected_bpm.size();
   end

endmodule

### verif/pulse_rate_meter_top_test.sv
// ----------------------------------------------------------------------------
// pulse_rate_meter_top_test
// Drives pulse and rate requests into the pulse rate meter through bursty
// traffic and a stalling response side, across several CSR settings and a
// short back-to-back pulse run; the monitor checks every rate.
// ----------------------------------------------------------------------------

module pulse_rate_meter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import prm_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 370;
   localparam int OFF_PHASE_ITEMS = 50;
   localparam int HOLD_CYCLES     = 1500;
   localparam int STEADY_RUN      = 30;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TIME_W-1:0]     req_tdata  = '0;
   logic                  req_tuser  = ACTION_PULSE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RATE_W-1:0]     rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_COUNT_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int                    mismatches;
   int                    rates_outstanding;
   int                    cycle_count    = 0;
   int unsigned           burst_left     = 0;
   logic                  hold_requested = 1'b0;
   logic                  hold_done      = 1'b0;
   int                    hold_count     = 0;
   int unsigned           segment_left   = 0;
   int unsigned           ready_odds     = 100;
   int unsigned           odds_menu [4]  = '{100, 50, 20, 85};

   always #10 clock = ~clock;

   pulse_rate_meter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pulse_rate_meter_monitor monitor (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .rates_outstanding (rates_outstanding)
   );

   // response side: one long hold when asked, otherwise stall odds per segment
   always @(posedge clock) begin
      if (hold_requested && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES) begin
            hold_done <= 1'b1;
         end
      end else begin
         if (segment_left == 0) begin
            ready_odds   <= odds_menu[$urandom_range(0, 3)];
            segment_left <= $urandom_range(20, 300);
         end else begin
            segment_left <= segment_left - 1;
         end
         rsp_tready <= ($urandom_range(0, 99) < ready_odds);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic offer_request(input logic act, input logic [TIME_W-1:0] now_ms,
                                input bit steady);
      int unsigned gap;
      gap = 0;
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 40);
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= now_ms;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rates_outstanding != 0);
      // a trailing pulse request may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] enable_word,
                                 input logic [CSR_DATA_W-1:0] refr);
      csr_valid <= 1'b1;
      csr_index <= REG_COUNT_ENABLE;
      csr_wdata <= enable_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_REFRACTORY;
      csr_wdata <= refr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [TIME_W-1:0] clock_ms;
      int unsigned       refr;
      int unsigned       phase_items;
      logic              enable_bit;
      logic              rate_pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: counting off, nothing elapsed
      offer_request(ACTION_RATE,  32'h0000_0000, 1'b0);
      offer_request(ACTION_PULSE, 32'd1000,      1'b0);
      offer_request(ACTION_RATE,  32'hFFFF_FFFF, 1'b0);

      wait_for_quiet();
      write_settings(16'd1, 16'd500);
      offer_request(ACTION_PULSE, 32'd500,       1'b0);
      offer_request(ACTION_PULSE, 32'd501,       1'b0);
      offer_request(ACTION_PULSE, 32'd1001,      1'b0);
      offer_request(ACTION_PULSE, 32'd1002,      1'b0);
      offer_request(ACTION_RATE,  32'd2000,      1'b0);
      offer_request(ACTION_PULSE, 32'hFFFF_FF00, 1'b0);
      offer_request(ACTION_PULSE, 32'h0000_0100, 1'b0);   // gap wraps past 2^32
      offer_request(ACTION_RATE,  32'hFFFF_FFFF, 1'b0);
      offer_request(ACTION_RATE,  32'h0000_0000, 1'b0);

      wait_for_quiet();
      write_settings(16'd1, 16'd0);
      offer_request(ACTION_PULSE, 32'h0000_0100, 1'b0);
      offer_request(ACTION_PULSE, 32'h0000_0101, 1'b0);
      offer_request(ACTION_RATE,  32'h8000_0000, 1'b0);

      wait_for_quiet();
      write_settings(16'd1, 16'hFFFF);
      offer_request(ACTION_PULSE, 32'h0001_0100, 1'b0);
      offer_request(ACTION_PULSE, 32'h0001_0101, 1'b0);
      offer_request(ACTION_RATE,  32'hFFFF_0000, 1'b0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         enable_bit  = (phase != 1);
         phase_items = (phase == 1) ? OFF_PHASE_ITEMS : ITEMS_PER_PHASE;
         refr = (phase == 3) ? 65535 :
                (phase == 5) ? $urandom_range(0, 65535) :
                (phase == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2000);
         write_settings({15'($urandom), enable_bit}, 16'(refr));
         if (phase == 2) begin
            hold_requested <= 1'b1;
         end
         clock_ms = $urandom;
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 39) == 0) begin
               clock_ms = $urandom;
            end else if ($urandom_range(0, 7) == 0) begin
               clock_ms = clock_ms + refr + $urandom_range(0, 1);
            end else begin
               clock_ms = clock_ms + $urandom_range(0, 2 * refr + 2);
            end
            if (hold_requested && !hold_done) begin
               rate_pick = ($urandom_range(0, 1) == 0);
            end else begin
               rate_pick = ($urandom_range(0, 7) == 0);
            end
            offer_request(rate_pick ? ACTION_RATE : ACTION_PULSE, clock_ms, 1'b0);
         end
      end

      // back-to-back pulses between two rate requests
      wait_for_quiet();
      write_settings(16'd1, 16'd0);
      clock_ms = $urandom;
      offer_request(ACTION_RATE, clock_ms, 1'b1);
      for (int n = 0; n < STEADY_RUN; n++) begin
         clock_ms = clock_ms + 1;
         offer_request(ACTION_PULSE, clock_ms, 1'b1);
      end
      clock_ms = clock_ms + 1;
      offer_request(ACTION_RATE, clock_ms, 1'b1);

      wait_for_quiet();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### pulse_rate_meter_top.f
rtl/core/prm_pkg.sv
rtl/core/pulse_rate_meter_top.sv
verif/pulse_rate_meter_monitor.sv
verif/pulse_rate_meter_top_test.sv
